// ===== hdl/frustum_sphere_cull_core_defines.svh =====
// assertion macros shared by the frustum sphere cull checker
// expects i_clk and i_rst_n in the scope of each use
`ifndef FRUSTUM_SPHERE_CULL_CORE_DEFINES_SVH
`define FRUSTUM_SPHERE_CULL_CORE_DEFINES_SVH

// same-cycle implication, off while reset is held
`define FSC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fsc check failed");

// next-cycle implication, off while reset is held
`define FSC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fsc check failed");

`endif

// ===== hdl/fsc_pkg.sv =====
// shared types and constants of the frustum sphere cull core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fsc_pkg;

    localparam int NUM_PLANES_DEF = 6;

    localparam int COORD_W  = 32;
    localparam int RADIUS_W = 31;
    localparam int PROD_W   = 2 * COORD_W;
    // three products and a scaled offset, never overflows
    localparam int DIST_W   = PROD_W + 2;
    // Q2.30 times Q16.16 gives Q.46, the offset and radius shift up by this
    localparam int FRAC_SHIFT = 30;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TEST = 1'b1;

    localparam logic [1:0] COEF_NX  = 2'd0;
    localparam logic [1:0] COEF_NY  = 2'd1;
    localparam logic [1:0] COEF_NZ  = 2'd2;
    localparam logic [1:0] COEF_OFS = 2'd3;

    typedef enum logic [1:0] {
        VERDICT_INSIDE    = 2'd0,
        VERDICT_INTERSECT = 2'd1,
        VERDICT_OUTSIDE   = 2'd2
    } t_verdict;

    typedef struct packed {
        logic signed [COORD_W-1:0] nx;
        logic signed [COORD_W-1:0] ny;
        logic signed [COORD_W-1:0] nz;
        logic signed [COORD_W-1:0] ofs;
    } t_plane;

    typedef struct packed {
        logic outside;
        logic below;
    } t_lane_flags;

endpackage

`default_nettype wire

// ===== hdl/fsc_if.sv =====
// request and result channels of the frustum sphere cull core
// depends on fsc_pkg
`timescale 1ns / 1ps
`default_nettype none

interface fsc_req_if import fsc_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic [2:0]                 plane_index;
    logic [1:0]                 coef_index;
    logic signed [COORD_W-1:0]  coef_value;
    logic signed [COORD_W-1:0]  center_x;
    logic signed [COORD_W-1:0]  center_y;
    logic signed [COORD_W-1:0]  center_z;
    logic [RADIUS_W-1:0]        sphere_radius;

    modport source (
        output valid, req_type, plane_index, coef_index, coef_value,
               center_x, center_y, center_z, sphere_radius,
        input  ready
    );
    modport sink (
        input  valid, req_type, plane_index, coef_index, coef_value,
               center_x, center_y, center_z, sphere_radius,
        output ready
    );
endinterface

interface fsc_res_if import fsc_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] verdict;

    modport source (output valid, verdict, input ready);
    modport sink   (input valid, verdict, output ready);
endinterface

`default_nettype wire

// ===== hdl/fsc_lane.sv =====
// one plane lane: products, distance sum and threshold compare, three stages
// depends on fsc_pkg
`timescale 1ns / 1ps
`default_nettype none

module fsc_lane import fsc_pkg::*; (
    input  wire                      i_clk,
    input  wire                      i_en,
    input  t_plane                   i_plane,
    input  wire signed [COORD_W-1:0] i_cx,
    input  wire signed [COORD_W-1:0] i_cy,
    input  wire signed [COORD_W-1:0] i_cz,
    input  wire signed [DIST_W-1:0]  i_pos,
    input  wire signed [DIST_W-1:0]  i_neg,
    output t_lane_flags              o_flags
);

    logic signed [PROD_W-1:0]  r_px, r_py, r_pz;
    logic signed [COORD_W-1:0] r_ofs;
    logic signed [DIST_W-1:0]  r_dist;
    t_lane_flags               r_flags;

    logic signed [PROD_W-1:0]  n_px, n_py, n_pz;
    logic signed [DIST_W-1:0]  n_dist;
    t_lane_flags               n_flags;

    always_comb begin
        n_px = i_plane.nx * i_cx;
        n_py = i_plane.ny * i_cy;
        n_pz = i_plane.nz * i_cz;
        n_dist = DIST_W'(r_px) + DIST_W'(r_py) + DIST_W'(r_pz)
               + (DIST_W'(r_ofs) <<< FRAC_SHIFT);
        n_flags.outside = r_dist < i_neg;
        n_flags.below   = r_dist < i_pos;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px    <= n_px;
            r_py    <= n_py;
            r_pz    <= n_pz;
            r_ofs   <= i_plane.ofs;
            r_dist  <= n_dist;
            r_flags <= n_flags;
        end
    end

    assign o_flags = r_flags;

endmodule

`default_nettype wire

// ===== hdl/frustum_sphere_cull_core.sv =====
// Sphere against frustum classifier. Plane coefficients are loaded one at a
// time into a flip-flop table that reset clears to zero; a load gives no
// result and is seen by every test accepted after it. A test item gives one
// verdict (inside, intersecting, outside) from its four registered stages,
// and one item is taken every cycle while no finished verdict waits. Every
// plane has its own lane of multipliers; the four stages are products,
// distance sum, threshold compare and verdict. The whole pipeline holds
// while a finished verdict is not taken, and no item is taken in that time.
`timescale 1ns / 1ps
`default_nettype none

module frustum_sphere_cull_core import fsc_pkg::*; #(
    parameter int NUM_PLANES = NUM_PLANES_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    fsc_req_if.sink    i_req,
    fsc_res_if.source  o_res
);

    t_plane      r_plane [NUM_PLANES];
    t_lane_flags w_flags [NUM_PLANES];

    logic                    r_v1, r_v2, r_v3, r_v4;
    logic [RADIUS_W-1:0]     r_rad1;
    logic signed [DIST_W-1:0] r_pos2, r_neg2;
    t_verdict                r_verdict;

    logic                    w_en;
    logic                    w_xfer;
    logic signed [DIST_W-1:0] w_pos;
    logic                    w_any_out, w_any_below;
    t_verdict                n_verdict;

    // one stall signal for all stages
    assign w_en        = !r_v4 || o_res.ready;
    assign i_req.ready = w_en;
    assign w_xfer      = i_req.valid && w_en;

    assign w_pos = DIST_W'({r_rad1, {FRAC_SHIFT{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PLANES; p++) begin
                r_plane[p] <= '0;
            end
        end else if (w_xfer && i_req.req_type == REQ_LOAD) begin
            for (int p = 0; p < NUM_PLANES; p++) begin
                if (5'(p) == 5'(i_req.plane_index)) begin
                    case (i_req.coef_index)
                        COEF_NX:  r_plane[p].nx  <= i_req.coef_value;
                        COEF_NY:  r_plane[p].ny  <= i_req.coef_value;
                        COEF_NZ:  r_plane[p].nz  <= i_req.coef_value;
                        COEF_OFS: r_plane[p].ofs <= i_req.coef_value;
                        default: ;
                    endcase
                end
            end
        end
    end

    for (genvar g = 0; g < NUM_PLANES; g++) begin : g_lane
        fsc_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_plane (r_plane[g]),
            .i_cx    (i_req.center_x),
            .i_cy    (i_req.center_y),
            .i_cz    (i_req.center_z),
            .i_pos   (r_pos2),
            .i_neg   (r_neg2),
            .o_flags (w_flags[g])
        );
    end

    always_comb begin
        w_any_out   = 1'b0;
        w_any_below = 1'b0;
        for (int p = 0; p < NUM_PLANES; p++) begin
            w_any_out   = w_any_out   | w_flags[p].outside;
            w_any_below = w_any_below | w_flags[p].below;
        end
        if (w_any_out) begin
            n_verdict = VERDICT_OUTSIDE;
        end else if (w_any_below) begin
            n_verdict = VERDICT_INTERSECT;
        end else begin
            n_verdict = VERDICT_INSIDE;
        end
    end

    // valid bits only for tests, loads leave a bubble
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= w_xfer && i_req.req_type == REQ_TEST;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rad1    <= i_req.sphere_radius;
            r_pos2    <= w_pos;
            r_neg2    <= -w_pos;
            r_verdict <= n_verdict;
        end
    end

    assign o_res.valid   = r_v4;
    assign o_res.verdict = r_verdict;

endmodule

`default_nettype wire

// ===== hdl/fsc_checker.sv =====
// port-level checks of the frustum sphere cull core, bound to the top level
// depends on fsc_pkg and frustum_sphere_cull_core_defines.svh
`timescale 1ns / 1ps
`default_nettype none

`include "frustum_sphere_cull_core_defines.svh"

module fsc_checker import fsc_pkg::*; (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_ready,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input wire [1:0] i_out_verdict
)
;

    // only the three verdict codes leave the block
    `FSC_ASSERT_NOW(a_verdict_code, i_out_valid,
        i_out_verdict == VERDICT_INSIDE || i_out_verdict == VERDICT_INTERSECT ||
        i_out_verdict == VERDICT_OUTSIDE)

    // a waiting verdict holds
    `FSC_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_out_verdict))

    // a waiting verdict stalls the input side
    `FSC_ASSERT_NOW(a_stall_in, i_out_valid && !i_out_ready, !i_in_ready)

    // the input side only stops while a verdict waits
    `FSC_ASSERT_NOW(a_ready_free, !i_in_ready, i_out_valid && !i_out_ready)

endmodule

bind frustum_sphere_cull_core fsc_checker u_fsc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_req.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_out_verdict (o_res.verdict)
);

`default_nettype wire

// ===== dv/fsc_cull_checker.sv =====
`timescale 1ns / 1ps
// scoreboard for the frustum sphere cull core: mirrors the plane table, predicts
// each verdict and compares it with the result channel; depends on fsc_pkg and fsc_if
module fsc_cull_checker import fsc_pkg::*; #(
    parameter int NUM_PLANES = NUM_PLANES_DEF
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    fsc_req_if    i_req,
    fsc_res_if    i_res,
    output int    o_fail_count,
    output int    o_pending
);

    logic signed [COORD_W-1:0] plane_tbl [NUM_PLANES][4];
    t_verdict                  verdict_q [$];

    // exact signed distances, wide enough for three products plus the offset
    function automatic t_verdict classify(input logic signed [COORD_W-1:0] cx,
                                          input logic signed [COORD_W-1:0] cy,
                                          input logic signed [COORD_W-1:0] cz,
                                          input logic [RADIUS_W-1:0] rad);
        logic signed [79:0]        plane_dist;
        logic signed [79:0]        lim;
        logic signed [79:0]        coef;
        logic signed [79:0]        crd;
        logic signed [COORD_W-1:0] centre [3];
        logic                      hit_out;
        logic                      hit_low;
        int                        p;
        int                        k;
        centre[0] = cx;
        centre[1] = cy;
        centre[2] = cz;
        lim = {49'd0, rad};
        lim = lim <<< FRAC_SHIFT;
        hit_out = 1'b0;
        hit_low = 1'b0;
        for (p = 0; p < NUM_PLANES; p++) begin
            coef = plane_tbl[p][COEF_OFS];
            plane_dist = coef <<< FRAC_SHIFT;
            for (k = 0; k < 3; k++) begin
                coef = plane_tbl[p][k];
                crd  = centre[k];
                plane_dist = plane_dist + coef * crd;
            end
            if (plane_dist < -lim) begin
                hit_out = 1'b1;
            end else if (plane_dist < lim) begin
                hit_low = 1'b1;
            end
        end
        if (hit_out) begin
            return VERDICT_OUTSIDE;
        end else if (hit_low) begin
            return VERDICT_INTERSECT;
        end
        return VERDICT_INSIDE;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_verdict want;
        int       p;
        int       k;
        if (!i_rst_n) begin
            for (p = 0; p < NUM_PLANES; p++) begin
                for (k = 0; k < 4; k++) begin
                    plane_tbl[p][k] = '0;
                end
            end
            verdict_q.delete();
        end else begin
            // results first, so a verdict never meets its own request's push
            if (i_res.valid && i_res.ready) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: verdict %0d with nothing expected, expected none",
                             $time, i_res.verdict);
                    o_fail_count++;
                end else begin
                    want = verdict_q.pop_front();
                    if (i_res.verdict !== want) begin
                        $display("%0t: verdict mismatch, expected %0d, got %0d",
                                 $time, want, i_res.verdict);
                        o_fail_count++;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                if (i_req.req_type == REQ_TEST) begin
                    verdict_q.push_back(classify(i_req.center_x, i_req.center_y,
                                                 i_req.center_z, i_req.sphere_radius));
                end else if (i_req.plane_index < NUM_PLANES) begin
                    plane_tbl[i_req.plane_index][i_req.coef_index] = i_req.coef_value;
                end
            end
        end
        o_pending <= verdict_q.size();
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// top of the frustum sphere cull testbench: clock, reset, request stimulus and
// result back-pressure; depends on fsc_pkg, fsc_if, the core and fsc_cull_checker
module testbench;
    import fsc_pkg::*;

    localparam int ONE          = 1 << 16;
    localparam int UNIT_NORMAL  = 1 << 30;
    localparam int NUM_ITEMS    = 1000;
    localparam int CALM_FROM    = 850;
    localparam int LIMIT_CYCLES = 200000;

    typedef struct packed {
        logic                      req_type;
        logic [2:0]                plane_index;
        logic [1:0]                coef_index;
        logic signed [COORD_W-1:0] coef_value;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_z;
        logic [RADIUS_W-1:0]       sphere_radius;
    } t_cull_req;

    logic clk = 1'b0;
    logic rst_n;
    bit   idle_on = 1'b1;
    int   n_items = 0;
    int   cycles  = 0;
    int   fails;
    int   pending;

    fsc_req_if req_ch ();
    fsc_res_if res_ch ();

    frustum_sphere_cull_core u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    fsc_cull_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_ch),
        .i_res        (res_ch),
        .o_fail_count (fails),
        .o_pending    (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // every field random, so don't-care fields toggle too
    function automatic t_cull_req random_req();
        t_cull_req r;
        r.req_type      = 1'($urandom_range(0, 1));
        r.plane_index   = 3'($urandom_range(0, 7));
        r.coef_index    = 2'($urandom_range(0, 3));
        r.coef_value    = $urandom;
        r.center_x      = $urandom;
        r.center_y      = $urandom;
        r.center_z      = $urandom;
        r.sphere_radius = 31'($urandom);
        return r;
    endfunction

    function automatic t_cull_req load_req(input logic [2:0] plane, input logic [1:0] coef,
                                           input logic signed [COORD_W-1:0] value);
        t_cull_req r;
        r             = random_req();
        r.req_type    = REQ_LOAD;
        r.plane_index = plane;
        r.coef_index  = coef;
        r.coef_value  = value;
        return r;
    endfunction

    function automatic t_cull_req test_req(input logic signed [COORD_W-1:0] cx,
                                           input logic signed [COORD_W-1:0] cy,
                                           input logic signed [COORD_W-1:0] cz,
                                           input logic [RADIUS_W-1:0] rad);
        t_cull_req r;
        r               = random_req();
        r.req_type      = REQ_TEST;
        r.center_x      = cx;
        r.center_y      = cy;
        r.center_z      = cz;
        r.sphere_radius = rad;
        return r;
    endfunction

    function automatic logic signed [COORD_W-1:0] scene_coord();
        return int'($urandom_range(0, 300 * ONE)) - 150 * ONE;
    endfunction

    // one transfer on the request channel, with an optional gap in front
    task automatic send_req(input t_cull_req r);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= r.req_type;
        req_ch.plane_index   <= r.plane_index;
        req_ch.coef_index    <= r.coef_index;
        req_ch.coef_value    <= r.coef_value;
        req_ch.center_x      <= r.center_x;
        req_ch.center_y      <= r.center_y;
        req_ch.center_z      <= r.center_z;
        req_ch.sphere_radius <= r.sphere_radius;
        do @(posedge clk); while (!req_ch.ready);
        if (r.req_type == REQ_TEST || r.plane_index < NUM_PLANES_DEF) begin
            n_items++;
            if (n_items % 64 == 0) idle_on = ($urandom_range(0, 3) != 0);
            if (n_items >= CALM_FROM) idle_on = 1'b0;
        end
    endtask

    // result side back-pressure
    initial begin
        res_ch.ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (idle_on && $urandom_range(0, 5) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    initial begin
        logic signed [COORD_W-1:0] nrm;
        logic [RADIUS_W-1:0]       rad;
        int                        pick;
        int                        p;
        int                        k;
        rst_n                <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.req_type      <= REQ_LOAD;
        req_ch.plane_index   <= '0;
        req_ch.coef_index    <= COEF_NX;
        req_ch.coef_value    <= '0;
        req_ch.center_x      <= '0;
        req_ch.center_y      <= '0;
        req_ch.center_z      <= '0;
        req_ch.sphere_radius <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // cleared table: a point is inside, a real sphere intersects
        send_req(test_req(32'sh7fff_ffff, 32'sh8000_0000, 0, 31'd0));
        send_req(test_req(-1, 1, 32'sh8000_0000, 31'h7fff_ffff));
        // loads past the last plane are dropped
        send_req(load_req(3'd6, COEF_NX, 32'sh7fff_ffff));
        send_req(load_req(3'd7, COEF_OFS, 32'sh8000_0000));
        send_req(test_req(0, 0, 0, 31'd0));
        // plane 0 is x >= -10
        send_req(load_req(3'd0, COEF_NX, UNIT_NORMAL));
        send_req(load_req(3'd0, COEF_OFS, 10 * ONE));
        send_req(test_req(0, 0, 0, 31'd0));
        send_req(test_req(-20 * ONE, 0, 0, 31'd0));
        send_req(test_req(-10 * ONE, 0, 0, 31'd0));
        send_req(test_req(-12 * ONE, 0, 0, 31'(5 * ONE)));
        send_req(test_req(-15 * ONE, 0, 0, 31'(5 * ONE)));
        // extreme coefficients against extreme centres
        send_req(load_req(3'd5, COEF_NX, 32'sh8000_0000));
        send_req(load_req(3'd5, COEF_NY, 32'sh7fff_ffff));
        send_req(load_req(3'd5, COEF_NZ, 32'sh8000_0000));
        send_req(load_req(3'd5, COEF_OFS, 32'sh7fff_ffff));
        send_req(test_req(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 31'h7fff_ffff));
        send_req(test_req(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 31'h7fff_ffff));
        send_req(test_req(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 31'd0));
        send_req(load_req(3'd5, COEF_OFS, 32'sh8000_0000));
        send_req(test_req(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 31'd0));

        while (n_items < NUM_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick <= 5) begin
                if (pick <= 3) begin
                    // box-like frustum around the origin, normals slightly tilted
                    for (p = 0; p < NUM_PLANES_DEF; p++) begin
                        for (k = 0; k < 3; k++) begin
                            nrm = int'($urandom_range(0, 1 << 27)) - (1 << 26);
                            if (k == p / 2) nrm = nrm + ((p % 2) ? -UNIT_NORMAL : UNIT_NORMAL);
                            send_req(load_req(3'(p), 2'(k), nrm));
                        end
                        send_req(load_req(3'(p), COEF_OFS, $urandom_range(ONE, 100 * ONE)));
                    end
                end else begin
                    repeat ($urandom_range(1, 4)) begin
                        send_req(load_req(3'($urandom_range(0, NUM_PLANES_DEF - 1)),
                                          2'($urandom_range(0, 3)), $urandom));
                    end
                end
                repeat ($urandom_range(5, 30)) begin
                    rad = 31'($urandom_range(0, 50 * ONE));
                    if ($urandom_range(0, 3) == 0) rad = '0;
                    else if ($urandom_range(0, 15) == 0) rad = 31'($urandom);
                    send_req(test_req(scene_coord(), scene_coord(), scene_coord(), rad));
                end
            end else if (pick <= 7) begin
                send_req(load_req(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                                  $urandom));
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_req(test_req($urandom, $urandom, $urandom, 31'($urandom)));
                end
            end
        end
        req_ch.valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (fails == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
